### sv/qslp_pkg.sv
// Shared widths, coefficient table and rounding helpers for the quaternion blend pipeline.
`default_nettype none
package qslp_pkg;

	localparam int CB      = 16;
	localparam int FB      = CB - 2;
	localparam int SH      = 2 * FB - 16;
	localparam int PW      = 2 * CB;
	localparam int CW      = 18;
	localparam int UW      = 20;
	localparam int CFW     = 18;
	localparam int KW      = 24;
	localparam int WW      = 26;
	localparam int RW      = 64;
	localparam int NSTG    = 9;
	localparam int IW      = 8 * CB + 16;
	localparam int IDW     = ((IW + 7) / 8) * 8;
	localparam int ODW     = ((4 * CB + 7) / 8) * 8;
	localparam int COS_ONE = 16384;
	localparam int Q_HALF  = 16384;

	typedef logic signed [CB-1:0]  comp_t;
	typedef logic signed [CB:0]    compx_t;
	typedef logic signed [PW-1:0]  prod_t;
	typedef logic signed [CW-1:0]  cos_t;
	typedef logic signed [UW-1:0]  uval_t;
	typedef logic signed [CFW-1:0] coef_t;
	typedef logic signed [KW-1:0]  kval_t;
	typedef logic signed [WW-1:0]  wval_t;
	typedef logic signed [RW-1:0]  wide_t;
	typedef logic [NSTG:1]         stg_t;

	// Row k holds the terms for cosine power k: constant, u, u^2, u^3 (Q.16).
	localparam coef_t COEF [4][4] = '{
		'{ 18'sd45785,  18'sd72362, -18'sd52128, -18'sd27104 },
		'{-18'sd17039, -18'sd7842,   18'sd66333,  18'sd30048 },
		'{ 18'sd2494,   18'sd661,   -18'sd5795,  -18'sd389   },
		'{ 18'sd1557,   18'sd355,   -18'sd8537,  -18'sd2573  }
	};

	localparam wide_t HALF16 = 64'sd32768;
	localparam prod_t THREE  = prod_t'(3);

	// Round to nearest with ties toward plus infinity, dropping 16 fraction bits.
	function automatic wide_t rnd16(input wide_t p);
		return (p + HALF16) >>> 16;
	endfunction

	// Divide by four, truncating toward zero.
	function automatic prod_t trunc4(input prod_t p);
		return p[PW-1] ? ((p + THREE) >>> 2) : (p >>> 2);
	endfunction

endpackage
`default_nettype wire

### sv/qslp_front.sv
// Stages one to three: dot product, cosine magnitude, blend offset powers and first coefficients.
`default_nettype none
module qslp_front (
	input  wire logic            clk,
	input  wire qslp_pkg::stg_t  en,
	input  wire qslp_pkg::comp_t qa [4],
	input  wire qslp_pkg::comp_t qb [4],
	input  wire logic [15:0]     blend,
	output qslp_pkg::comp_t      qa_s3 [4],
	output qslp_pkg::compx_t     bv_s3 [4],
	output logic                 flip_s3,
	output qslp_pkg::cos_t       c16_s3,
	output qslp_pkg::uval_t      u3_s3,
	output qslp_pkg::kval_t      ak_s3 [4],
	output qslp_pkg::kval_t      pb1_s3 [4]
);

	localparam int UPW = 2 * qslp_pkg::UW;
	localparam int KPW = qslp_pkg::CFW + qslp_pkg::UW;

	qslp_pkg::prod_t prod_s1 [4];
	qslp_pkg::comp_t qa_s1 [4];
	qslp_pkg::comp_t qb_s1 [4];
	qslp_pkg::uval_t u16_s1;

	qslp_pkg::prod_t dot_s2;
	qslp_pkg::comp_t qa_s2 [4];
	qslp_pkg::comp_t qb_s2 [4];
	qslp_pkg::uval_t u16_s2;
	qslp_pkg::uval_t u2_s2;

	qslp_pkg::uval_t         u16_in;
	logic signed [UPW-1:0]   pu2;
	logic signed [UPW-1:0]   pu3;
	qslp_pkg::prod_t         dot_sum;
	logic [qslp_pkg::PW-1:0] mag;
	logic [qslp_pkg::PW-1:0] msh;
	logic [14:0]             cmag;
	logic                    flip;
	logic signed [KPW-1:0]   pak [4];
	logic signed [KPW-1:0]   pbk [4];

	always_comb begin
		u16_in = (qslp_pkg::uval_t'({1'b0, blend}) - qslp_pkg::uval_t'(qslp_pkg::Q_HALF)) <<< 1;
		pu2 = u16_s1 * u16_s1;
		dot_sum = '0;
		for (int i = 0; i < 4; i++) begin
			dot_sum = dot_sum + qslp_pkg::trunc4(prod_s1[i]);
		end
		flip = dot_s2[qslp_pkg::PW-1];
		mag = flip ? qslp_pkg::PW'(-dot_s2) : qslp_pkg::PW'(dot_s2);
		msh = mag >> qslp_pkg::SH;
		cmag = (msh > qslp_pkg::PW'(qslp_pkg::COS_ONE)) ? 15'(qslp_pkg::COS_ONE) : msh[14:0];
		pu3 = u2_s2 * u16_s2;
		for (int k = 0; k < 4; k++) begin
			pak[k] = qslp_pkg::COEF[k][2] * u2_s2;
			pbk[k] = qslp_pkg::COEF[k][1] * u16_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int i = 0; i < 4; i++) begin
				prod_s1[i] <= qa[i] * qb[i];
				qa_s1[i] <= qa[i];
				qb_s1[i] <= qb[i];
			end
			u16_s1 <= u16_in;
		end
		if (en[2]) begin
			dot_s2 <= dot_sum;
			qa_s2 <= qa_s1;
			qb_s2 <= qb_s1;
			u16_s2 <= u16_s1;
			u2_s2 <= qslp_pkg::UW'(qslp_pkg::rnd16(qslp_pkg::RW'(pu2)));
		end
		if (en[3]) begin
			flip_s3 <= flip;
			c16_s3 <= qslp_pkg::CW'({cmag, 2'b00});
			u3_s3 <= qslp_pkg::UW'(qslp_pkg::rnd16(qslp_pkg::RW'(pu3)));
			for (int i = 0; i < 4; i++) begin
				qa_s3[i] <= qa_s2[i];
				bv_s3[i] <= flip ? -qslp_pkg::compx_t'(qb_s2[i]) : qslp_pkg::compx_t'(qb_s2[i]);
			end
			for (int k = 0; k < 4; k++) begin
				ak_s3[k] <= qslp_pkg::kval_t'(qslp_pkg::COEF[k][0])
					+ qslp_pkg::KW'(qslp_pkg::rnd16(qslp_pkg::RW'(pak[k])));
				pb1_s3[k] <= qslp_pkg::KW'(qslp_pkg::rnd16(qslp_pkg::RW'(pbk[k])));
			end
		end
	end

endmodule
`default_nettype wire

### sv/qslp_poly.sv
// Stages four to seven: cosine powers, cubic evaluation and the two blend weights.
`default_nettype none
module qslp_poly (
	input  wire logic             clk,
	input  wire qslp_pkg::stg_t   en,
	input  wire qslp_pkg::comp_t  qa_s3 [4],
	input  wire qslp_pkg::compx_t bv_s3 [4],
	input  wire logic             flip_s3,
	input  wire qslp_pkg::cos_t   c16_s3,
	input  wire qslp_pkg::uval_t  u3_s3,
	input  wire qslp_pkg::kval_t  ak_s3 [4],
	input  wire qslp_pkg::kval_t  pb1_s3 [4],
	output qslp_pkg::comp_t       qa_s7 [4],
	output qslp_pkg::compx_t      bv_s7 [4],
	output logic                  flip_s7,
	output qslp_pkg::wval_t       w0_s7,
	output qslp_pkg::wval_t       w1_s7
);

	localparam int CPW = 2 * qslp_pkg::CW;
	localparam int BPW = qslp_pkg::CFW + qslp_pkg::UW;
	localparam int TPW = qslp_pkg::KW + qslp_pkg::CW;

	qslp_pkg::comp_t  qa_s4 [4];
	qslp_pkg::compx_t bv_s4 [4];
	logic             flip_s4;
	qslp_pkg::cos_t   c16_s4;
	qslp_pkg::cos_t   c2_s4;
	qslp_pkg::kval_t  ak_s4 [4];
	qslp_pkg::kval_t  bk_s4 [4];

	qslp_pkg::comp_t  qa_s5 [4];
	qslp_pkg::compx_t bv_s5 [4];
	logic             flip_s5;
	qslp_pkg::cos_t   c3_s5;
	qslp_pkg::kval_t  ak0_s5;
	qslp_pkg::kval_t  bk0_s5;
	qslp_pkg::kval_t  ak3_s5;
	qslp_pkg::kval_t  bk3_s5;
	qslp_pkg::kval_t  ta1_s5;
	qslp_pkg::kval_t  tb1_s5;
	qslp_pkg::kval_t  ta2_s5;
	qslp_pkg::kval_t  tb2_s5;

	qslp_pkg::comp_t  qa_s6 [4];
	qslp_pkg::compx_t bv_s6 [4];
	logic             flip_s6;
	qslp_pkg::kval_t  pa_s6;
	qslp_pkg::kval_t  pb_s6;
	qslp_pkg::kval_t  ta3_s6;
	qslp_pkg::kval_t  tb3_s6;

	logic signed [CPW-1:0] pc2;
	logic signed [CPW-1:0] pc3;
	logic signed [BPW-1:0] pb3 [4];
	logic signed [TPW-1:0] pta1, ptb1, pta2, ptb2, pta3, ptb3;
	qslp_pkg::wval_t       asum, bsum;

	always_comb begin
		pc2 = c16_s3 * c16_s3;
		for (int k = 0; k < 4; k++) begin
			pb3[k] = qslp_pkg::COEF[k][3] * u3_s3;
		end
		pc3 = c2_s4 * c16_s4;
		pta1 = ak_s4[1] * c16_s4;
		ptb1 = bk_s4[1] * c16_s4;
		pta2 = ak_s4[2] * c2_s4;
		ptb2 = bk_s4[2] * c2_s4;
		pta3 = ak3_s5 * c3_s5;
		ptb3 = bk3_s5 * c3_s5;
		asum = qslp_pkg::wval_t'(pa_s6) + qslp_pkg::wval_t'(ta3_s6);
		bsum = qslp_pkg::wval_t'(pb_s6) + qslp_pkg::wval_t'(tb3_s6);
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			qa_s4 <= qa_s3;
			bv_s4 <= bv_s3;
			flip_s4 <= flip_s3;
			c16_s4 <= c16_s3;
			c2_s4 <= qslp_pkg::CW'(qslp_pkg::rnd16(qslp_pkg::RW'(pc2)));
			ak_s4 <= ak_s3;
			for (int k = 0; k < 4; k++) begin
				bk_s4[k] <= pb1_s3[k] + qslp_pkg::KW'(qslp_pkg::rnd16(qslp_pkg::RW'(pb3[k])));
			end
		end
		if (en[5]) begin
			qa_s5 <= qa_s4;
			bv_s5 <= bv_s4;
			flip_s5 <= flip_s4;
			c3_s5 <= qslp_pkg::CW'(qslp_pkg::rnd16(qslp_pkg::RW'(pc3)));
			ak0_s5 <= ak_s4[0];
			bk0_s5 <= bk_s4[0];
			ak3_s5 <= ak_s4[3];
			bk3_s5 <= bk_s4[3];
			ta1_s5 <= qslp_pkg::KW'(qslp_pkg::rnd16(qslp_pkg::RW'(pta1)));
			tb1_s5 <= qslp_pkg::KW'(qslp_pkg::rnd16(qslp_pkg::RW'(ptb1)));
			ta2_s5 <= qslp_pkg::KW'(qslp_pkg::rnd16(qslp_pkg::RW'(pta2)));
			tb2_s5 <= qslp_pkg::KW'(qslp_pkg::rnd16(qslp_pkg::RW'(ptb2)));
		end
		if (en[6]) begin
			qa_s6 <= qa_s5;
			bv_s6 <= bv_s5;
			flip_s6 <= flip_s5;
			pa_s6 <= ak0_s5 + ta1_s5 + ta2_s5;
			pb_s6 <= bk0_s5 + tb1_s5 + tb2_s5;
			ta3_s6 <= qslp_pkg::KW'(qslp_pkg::rnd16(qslp_pkg::RW'(pta3)));
			tb3_s6 <= qslp_pkg::KW'(qslp_pkg::rnd16(qslp_pkg::RW'(ptb3)));
		end
		if (en[7]) begin
			qa_s7 <= qa_s6;
			bv_s7 <= bv_s6;
			flip_s7 <= flip_s6;
			w0_s7 <= asum - bsum;
			w1_s7 <= asum + bsum;
		end
	end

endmodule
`default_nettype wire

### sv/qslp_mix.sv
// Stages eight and nine: weighted sum of the two quaternions, rounding and saturation.
`default_nettype none
module qslp_mix (
	input  wire logic             clk,
	input  wire qslp_pkg::stg_t   en,
	input  wire qslp_pkg::comp_t  qa_s7 [4],
	input  wire qslp_pkg::compx_t bv_s7 [4],
	input  wire logic             flip_s7,
	input  wire qslp_pkg::wval_t  w0_s7,
	input  wire qslp_pkg::wval_t  w1_s7,
	output qslp_pkg::comp_t       out_s9 [4],
	output logic                  flip_s9
);

	localparam int MPW = qslp_pkg::WW + qslp_pkg::CB + 1;
	localparam int AW  = MPW + 1;
	localparam qslp_pkg::comp_t CMAX = {1'b0, {(qslp_pkg::CB - 1){1'b1}}};
	localparam qslp_pkg::comp_t CMIN = {1'b1, {(qslp_pkg::CB - 1){1'b0}}};

	logic signed [MPW-1:0] pw1_s8 [4];
	logic signed [MPW-1:0] pw0_s8 [4];
	logic                  flip_s8;

	logic signed [AW-1:0]  acc [4];
	qslp_pkg::wide_t       rv [4];
	qslp_pkg::comp_t       sat [4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			acc[i] = AW'(pw1_s8[i]) + AW'(pw0_s8[i]);
			rv[i] = qslp_pkg::rnd16(qslp_pkg::RW'(acc[i]));
			if (rv[i] > qslp_pkg::RW'(CMAX)) begin
				sat[i] = CMAX;
			end else if (rv[i] < qslp_pkg::RW'(CMIN)) begin
				sat[i] = CMIN;
			end else begin
				sat[i] = rv[i][qslp_pkg::CB-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[8]) begin
			for (int i = 0; i < 4; i++) begin
				pw1_s8[i] <= w1_s7 * bv_s7[i];
				pw0_s8[i] <= w0_s7 * qa_s7[i];
			end
			flip_s8 <= flip_s7;
		end
		if (en[9]) begin
			out_s9 <= sat;
			flip_s9 <= flip_s8;
		end
	end

endmodule
`default_nettype wire

### sv/quat_slerp_poly_approx.sv
// Top level of the polynomial quaternion blend: stream ports, stage valids and flow control.
// Each input transfer passes through the nine-stage multiply pipeline to the output.
// Throughput is one quaternion pair per cycle unless a stalled output fills the pipeline.
// A stalled output holds its result while empty stages upstream keep filling.
// Reset clears only the stage valid bits; data registers are not reset.
`default_nettype none
module quat_slerp_poly_approx (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	// a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, blend
	input  wire logic [qslp_pkg::IDW-1:0] s_tdata,
	output logic                          m_tvalid,
	input  wire logic                     m_tready,
	// out_w, out_x, out_y, out_z
	output logic [qslp_pkg::ODW-1:0]      m_tdata,
	// flipped
	output logic                          m_tuser
);

	qslp_pkg::stg_t   en;
	qslp_pkg::stg_t   vld_q;
	logic [qslp_pkg::NSTG:0] vin;

	qslp_pkg::comp_t  qa [4];
	qslp_pkg::comp_t  qb [4];
	logic [15:0]      blend;

	qslp_pkg::comp_t  qa_s3 [4];
	qslp_pkg::compx_t bv_s3 [4];
	logic             flip_s3;
	qslp_pkg::cos_t   c16_s3;
	qslp_pkg::uval_t  u3_s3;
	qslp_pkg::kval_t  ak_s3 [4];
	qslp_pkg::kval_t  pb1_s3 [4];

	qslp_pkg::comp_t  qa_s7 [4];
	qslp_pkg::compx_t bv_s7 [4];
	logic             flip_s7;
	qslp_pkg::wval_t  w0_s7;
	qslp_pkg::wval_t  w1_s7;

	qslp_pkg::comp_t  out_s9 [4];
	logic             flip_s9;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			qa[i] = s_tdata[i*qslp_pkg::CB +: qslp_pkg::CB];
			qb[i] = s_tdata[(i+4)*qslp_pkg::CB +: qslp_pkg::CB];
		end
		blend = s_tdata[8*qslp_pkg::CB +: 16];
	end

	// A stage may load when it is empty or the stage after it is loading.
	always_comb begin
		en[qslp_pkg::NSTG] = !vld_q[qslp_pkg::NSTG] || m_tready;
		for (int k = qslp_pkg::NSTG - 1; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
		vin = {vld_q, s_tvalid};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 1; k <= qslp_pkg::NSTG; k++) begin
				if (en[k]) begin
					vld_q[k] <= vin[k-1];
				end
			end
		end
	end

	assign s_tready = en[1];
	assign m_tvalid = vld_q[qslp_pkg::NSTG];
	assign m_tdata  = qslp_pkg::ODW'({out_s9[3], out_s9[2], out_s9[1], out_s9[0]});
	assign m_tuser  = flip_s9;

	qslp_front u_front (
		.clk     (clk),
		.en      (en),
		.qa      (qa),
		.qb      (qb),
		.blend   (blend),
		.qa_s3   (qa_s3),
		.bv_s3   (bv_s3),
		.flip_s3 (flip_s3),
		.c16_s3  (c16_s3),
		.u3_s3   (u3_s3),
		.ak_s3   (ak_s3),
		.pb1_s3  (pb1_s3)
	);

	qslp_poly u_poly (
		.clk     (clk),
		.en      (en),
		.qa_s3   (qa_s3),
		.bv_s3   (bv_s3),
		.flip_s3 (flip_s3),
		.c16_s3  (c16_s3),
		.u3_s3   (u3_s3),
		.ak_s3   (ak_s3),
		.pb1_s3  (pb1_s3),
		.qa_s7   (qa_s7),
		.bv_s7   (bv_s7),
		.flip_s7 (flip_s7),
		.w0_s7   (w0_s7),
		.w1_s7   (w1_s7)
	);

	qslp_mix u_mix (
		.clk     (clk),
		.en      (en),
		.qa_s7   (qa_s7),
		.bv_s7   (bv_s7),
		.flip_s7 (flip_s7),
		.w0_s7   (w0_s7),
		.w1_s7   (w1_s7),
		.out_s9  (out_s9),
		.flip_s9 (flip_s9)
	);

endmodule
`default_nettype wire

### test/testbench.sv
// Self-checking testbench for the polynomial quaternion blend: a directed table, then random pairs.
`timescale 1ns / 100ps
module testbench;

	typedef qslp_pkg::comp_t [3:0] quat_t;

	typedef struct packed {
		logic [15:0] t;
		quat_t       b;
		quat_t       a;
	} quat_pair_t;

	typedef struct packed {
		quat_t q;
		logic  flip;
	} blend_res_t;

	typedef struct packed {
		logic [15:0] aw, ax, ay, az, bw, bx, by, bz, t;
		logic        fixed;
		logic [63:0] want_q;
		logic        want_flip;
	} dir_row_t;

	localparam int COS_SHIFT = 12;
	localparam int COS_UNITY = 16384;
	localparam int N_RANDOM  = 700;

	localparam longint BLEND_COEF [4][4] = '{
		'{ 64'sd45785,  64'sd72362, -64'sd52128, -64'sd27104 },
		'{-64'sd17039, -64'sd7842,   64'sd66333,  64'sd30048 },
		'{ 64'sd2494,   64'sd661,   -64'sd5795,  -64'sd389   },
		'{ 64'sd1557,   64'sd355,   -64'sd8537,  -64'sd2573  }
	};

	// The all-zero rows have an all-zero result; every other row goes through the predictor.
	localparam dir_row_t DIRECTED [20] = '{
		'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
			16'h0000, 1'b1, 64'h0, 1'b0},
		'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
			16'h8000, 1'b1, 64'h0, 1'b0},
		'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
			16'hFFFF, 1'b1, 64'h0, 1'b0},
		'{16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h0000,
			16'h0000, 1'b0, 64'h0, 1'b0},
		'{16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h0000,
			16'h8000, 1'b0, 64'h0, 1'b0},
		'{16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h0000,
			16'h4000, 1'b0, 64'h0, 1'b0},
		'{16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000,
			16'h4000, 1'b0, 64'h0, 1'b0},
		'{16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'hC000, 16'h0000, 16'h0000, 16'h0000,
			16'h2000, 1'b0, 64'h0, 1'b0},
		'{16'h2D41, 16'h2D41, 16'h0000, 16'h0000, 16'h2D41, 16'h0000, 16'h2D41, 16'h0000,
			16'h4000, 1'b0, 64'h0, 1'b0},
		'{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
			16'h4000, 1'b0, 64'h0, 1'b0},
		'{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
			16'h8000, 1'b0, 64'h0, 1'b0},
		'{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
			16'h0000, 1'b0, 64'h0, 1'b0},
		'{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
			16'hFFFF, 1'b0, 64'h0, 1'b0},
		'{16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000,
			16'hFFFF, 1'b0, 64'h0, 1'b0},
		'{16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'hC000, 16'h0000, 16'h0000,
			16'h0001, 1'b0, 64'h0, 1'b0},
		'{16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0000,
			16'h7FFF, 1'b0, 64'h0, 1'b0},
		'{16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001, 16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF,
			16'h8000, 1'b0, 64'h0, 1'b0},
		'{16'hC000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hC000,
			16'h2000, 1'b0, 64'h0, 1'b0},
		'{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
			16'hC000, 1'b0, 64'h0, 1'b0},
		'{16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h3FFF, 16'h0100, 16'h0000, 16'h0000,
			16'h6000, 1'b0, 64'h0, 1'b0}
	};

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     s_tvalid;
	logic                     s_tready;
	logic [qslp_pkg::IDW-1:0] s_tdata;
	logic                     m_tvalid;
	logic                     m_tready;
	logic [qslp_pkg::ODW-1:0] m_tdata;
	logic                     m_tuser;

	blend_res_t          blend_q [$];
	int                  n_sent = 0;
	int                  mismatches = 0;
	int                  hold_left = 0;
	bit                  hold_done = 1'b0;
	logic                calm;

	assign calm = (n_sent >= 400 && n_sent < 520);

	quat_slerp_poly_approx u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #1 clk = ~clk;

	function automatic longint round_q16(input longint v);
		return (v + 64'sd32768) >>> 16;
	endfunction

	function automatic blend_res_t predict_blend(input quat_pair_t p);
		longint     qa [4];
		longint     qb [4];
		longint     ak [4];
		longint     bk [4];
		longint     dot, mag, c1, c2, c3, u1, u2, u3, asum, bsum, w0, w1, acc;
		blend_res_t r;
		dot = 0;
		for (int i = 0; i < 4; i++) begin
			qa[i] = longint'($signed(p.a[i]));
			qb[i] = longint'($signed(p.b[i]));
			dot += (qa[i] * qb[i]) / 4;
		end
		r.flip = dot < 0;
		mag = (r.flip ? -dot : dot) >>> COS_SHIFT;
		if (mag > COS_UNITY)
			mag = COS_UNITY;
		c1 = mag * 4;
		c2 = round_q16(c1 * c1);
		c3 = round_q16(c2 * c1);
		u1 = (longint'(p.t) - 16384) * 2;
		u2 = round_q16(u1 * u1);
		u3 = round_q16(u2 * u1);
		for (int k = 0; k < 4; k++) begin
			ak[k] = BLEND_COEF[k][0] + round_q16(BLEND_COEF[k][2] * u2);
			bk[k] = round_q16(BLEND_COEF[k][1] * u1) + round_q16(BLEND_COEF[k][3] * u3);
		end
		asum = ak[0] + round_q16(ak[1] * c1) + round_q16(ak[2] * c2) + round_q16(ak[3] * c3);
		bsum = bk[0] + round_q16(bk[1] * c1) + round_q16(bk[2] * c2) + round_q16(bk[3] * c3);
		w0 = asum - bsum;
		w1 = asum + bsum;
		for (int i = 0; i < 4; i++) begin
			acc = round_q16(w1 * (r.flip ? -qb[i] : qb[i]) + w0 * qa[i]);
			if (acc > 32767)
				acc = 32767;
			else if (acc < -32768)
				acc = -32768;
			r.q[i] = acc[15:0];
		end
		return r;
	endfunction

	function automatic int rand_span(input int span);
		int v;
		v = int'($urandom_range(2 * span));
		return v - span;
	endfunction

	function automatic quat_t unit_quat(input int v0, input int v1, input int v2, input int v3);
		real   n;
		quat_t q;
		n = $sqrt($itor(v0) * $itor(v0) + $itor(v1) * $itor(v1) +
			$itor(v2) * $itor(v2) + $itor(v3) * $itor(v3));
		if (n < 1.0)
			return {16'h0000, 16'h0000, 16'h0000, 16'h4000};
		q[0] = qslp_pkg::comp_t'($rtoi($itor(v0) * 16384.0 / n));
		q[1] = qslp_pkg::comp_t'($rtoi($itor(v1) * 16384.0 / n));
		q[2] = qslp_pkg::comp_t'($rtoi($itor(v2) * 16384.0 / n));
		q[3] = qslp_pkg::comp_t'($rtoi($itor(v3) * 16384.0 / n));
		return q;
	endfunction

	function automatic quat_t raw_quat();
		quat_t q;
		for (int i = 0; i < 4; i++)
			q[i] = qslp_pkg::comp_t'($urandom);
		return q;
	endfunction

	function automatic quat_pair_t random_pair();
		quat_pair_t p;
		int         kind;
		int         sel;
		int         sgn;
		kind = int'($urandom_range(99));
		sel = int'($urandom_range(99));
		sgn = $urandom_range(1) ? -1 : 1;
		p.a = unit_quat(rand_span(16384), rand_span(16384), rand_span(16384), rand_span(16384));
		if (kind < 50) begin
			p.b = unit_quat(rand_span(16384), rand_span(16384), rand_span(16384),
				rand_span(16384));
		end else if (kind < 82) begin
			p.b = unit_quat(sgn * int'($signed(p.a[0])) + rand_span(1500),
				sgn * int'($signed(p.a[1])) + rand_span(1500),
				sgn * int'($signed(p.a[2])) + rand_span(1500),
				sgn * int'($signed(p.a[3])) + rand_span(1500));
		end else if (kind < 91) begin
			p.b = raw_quat();
		end else begin
			p.a = raw_quat();
			p.b = raw_quat();
		end
		if (sel < 78)
			p.t = 16'($urandom_range(32768));
		else if (sel < 90)
			p.t = $urandom_range(1) ? 16'h8000 : 16'h0000;
		else
			p.t = 16'($urandom);
		return p;
	endfunction

	task automatic send_pair(input quat_pair_t p, input blend_res_t res);
		if (!calm && $urandom_range(99) < 13) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {p.t, p.b, p.a};
		do @(posedge clk); while (!s_tready);
		blend_q.push_back(res);
		n_sent++;
	endtask

	initial begin
		dir_row_t   row;
		quat_pair_t p;
		blend_res_t res;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		for (int n = 0; n < $size(DIRECTED); n++) begin
			row = DIRECTED[n];
			p.a = {row.az, row.ay, row.ax, row.aw};
			p.b = {row.bz, row.by, row.bx, row.bw};
			p.t = row.t;
			if (row.fixed) begin
				res.q = row.want_q;
				res.flip = row.want_flip;
			end else begin
				res = predict_blend(p);
			end
			send_pair(p, res);
		end
		for (int n = 0; n < N_RANDOM; n++) begin
			p = random_pair();
			send_pair(p, predict_blend(p));
		end
		s_tvalid <= 1'b0;
		while (blend_q.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// The receiver stalls at random, stays ready through the calm window, and holds off once
	// for a long stretch so that the pipeline fills and pushes back on the sender.
	initial begin
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (!hold_done && n_sent >= 150) begin
				m_tready <= 1'b0;
				hold_left = 100;
				hold_done = 1'b1;
			end else if (calm) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= 13);
			end
		end
	end

	always @(posedge clk) begin
		blend_res_t got;
		blend_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.q = m_tdata;
			got.flip = m_tuser;
			if (blend_q.size() == 0) begin
				if (mismatches < 10)
					$display("Unexpected output transfer at %0t: w=%0d x=%0d y=%0d z=%0d flipped=%0d",
						$realtime, $signed(got.q[0]), $signed(got.q[1]), $signed(got.q[2]),
						$signed(got.q[3]), got.flip);
				mismatches++;
			end else begin
				want = blend_q.pop_front();
				if (got !== want) begin
					if (mismatches < 10)
						$display({"Mismatch at %0t: expected w=%0d x=%0d y=%0d z=%0d flipped=%0d,",
							" got w=%0d x=%0d y=%0d z=%0d flipped=%0d"}, $realtime,
							$signed(want.q[0]), $signed(want.q[1]), $signed(want.q[2]),
							$signed(want.q[3]), want.flip, $signed(got.q[0]), $signed(got.q[1]),
							$signed(got.q[2]), $signed(got.q[3]), got.flip);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#200000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
